### sv/assert_macros.svh
// assertion helpers for the climate controller
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/fhcc_pkg.sv
`default_nettype none
package fhcc_pkg;

  typedef enum logic [2:0] {
    M_OFF     = 3'd0,
    M_ON      = 3'd1,
    M_COOL    = 3'd2,
    M_CYC_ON  = 3'd3,
    M_CYC_OFF = 3'd4,
    M_SB_OFF  = 3'd5
  } fan_mode_e;

  typedef enum logic [1:0] {
    SYS_OFF = 2'd0,
    SYS_ON  = 2'd1,
    SYS_SB  = 2'd2,
    SYS_BAD = 2'd3
  } sys_mode_e;

  typedef enum logic [2:0] {
    REG_COOLDOWN = 3'd0,
    REG_RAMP     = 3'd1,
    REG_TLIMIT   = 3'd2,
    REG_MINPWM   = 3'd3,
    REG_COOLPWM  = 3'd4,
    REG_SBPWM    = 3'd5,
    REG_OFFPWM   = 3'd6
  } reg_idx_e;

  typedef enum logic [2:0] {
    C_IDLE,
    C_FSM,
    C_PROP,
    C_GOAL,
    C_SETUP,
    C_DIV,
    C_OUT
  } ctrl_e;

  localparam int TEMP_REARM = 30;
  localparam int HUM_REARM  = 20;
  localparam int PWM_MAX    = 255;
  localparam int DIV_BITS   = 24;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture item
    logic fsm;       // run state update or power set
    logic prop;      // compute proportional speed
    logic goal;      // choose goal, start ramp step
    logic div_step;  // one restoring division bit
    logic finish;    // apply ramp result, present item
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_power;
    logic need_div;
    logic div_done;
  } sts_t;

endpackage
`default_nettype wire

### sv/fhcc_ctrl.sv
`default_nettype none
module fhcc_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  input  wire fhcc_pkg::sts_t  sts_i,
  output fhcc_pkg::cmd_t       cmd_o
);

  fhcc_pkg::ctrl_e state_q, state_d;
  logic out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fhcc_pkg::C_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    out_valid_d = out_valid_q & ~out_ready_i;
    case (state_q)
      fhcc_pkg::C_IDLE: begin
        // next item may enter while the previous result still waits
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = fhcc_pkg::C_FSM;
        end
      end
      fhcc_pkg::C_FSM: begin
        cmd_o.fsm = 1'b1;
        state_d = sts_i.is_power ? fhcc_pkg::C_OUT : fhcc_pkg::C_PROP;
      end
      fhcc_pkg::C_PROP: begin
        cmd_o.prop = 1'b1;
        state_d = fhcc_pkg::C_GOAL;
      end
      fhcc_pkg::C_GOAL: begin
        cmd_o.goal = 1'b1;
        state_d = fhcc_pkg::C_SETUP;
      end
      // divider loads its operands from the new goal
      fhcc_pkg::C_SETUP: begin
        state_d = fhcc_pkg::C_DIV;
      end
      fhcc_pkg::C_DIV: begin
        if (sts_i.need_div && !sts_i.div_done) cmd_o.div_step = 1'b1;
        else state_d = fhcc_pkg::C_OUT;
      end
      fhcc_pkg::C_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.finish = 1'b1;
          out_valid_d = 1'b1;
          state_d = fhcc_pkg::C_IDLE;
        end
      end
      default: state_d = fhcc_pkg::C_IDLE;
    endcase
  end

endmodule
`default_nettype wire

### sv/fhcc_dp.sv
`default_nettype none
module fhcc_dp #(
  parameter int TIME_WIDTH = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire fhcc_pkg::cmd_t     cmd_i,
  output fhcc_pkg::sts_t          sts_o,
  input  wire logic               cfg_we_i,
  input  wire logic [2:0]         cfg_index_i,
  input  wire logic [31:0]        cfg_data_i,
  input  wire logic               command_i,
  input  wire logic [31:0]        now_ms_i,
  input  wire logic [1:0]         system_mode_i,
  input  wire logic [1:0]         control_mode_i,
  input  wire logic signed [11:0] temperature_i,
  input  wire logic [9:0]         humidity_i,
  input  wire logic signed [11:0] target_temp_i,
  input  wire logic [9:0]         target_humidity_i,
  input  wire logic               cooldown_required_i,
  input  wire logic               heater_allowed_i,
  input  wire logic signed [15:0] power_request_i,
  output logic [7:0]              fan_pwm_o,
  output logic [7:0]              heater_pwm_o,
  output logic [2:0]              fan_mode_o,
  output logic                    fan_running_o,
  output logic                    heater_on_o
);

  localparam int TW = TIME_WIDTH;
  localparam int DB = fhcc_pkg::DIV_BITS;
  localparam int CW = $clog2(DB + 1);

  // configuration
  logic [31:0] cool_time_q;
  logic [15:0] ramp_time_q;
  logic signed [11:0] tlimit_q;
  logic [7:0] min_pwm_q, cool_pwm_q, sb_pwm_q, off_pwm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cool_time_q <= 32'd60000;
      ramp_time_q <= 16'd2000;
      tlimit_q    <= 12'sd600;
      min_pwm_q   <= 8'd100;
      cool_pwm_q  <= 8'd255;
      sb_pwm_q    <= 8'd128;
      off_pwm_q   <= 8'd0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        fhcc_pkg::REG_COOLDOWN: cool_time_q <= cfg_data_i;
        fhcc_pkg::REG_RAMP:     ramp_time_q <= cfg_data_i[15:0];
        fhcc_pkg::REG_TLIMIT:   tlimit_q    <= cfg_data_i[11:0];
        fhcc_pkg::REG_MINPWM:   min_pwm_q   <= cfg_data_i[7:0];
        fhcc_pkg::REG_COOLPWM:  cool_pwm_q  <= cfg_data_i[7:0];
        fhcc_pkg::REG_SBPWM:    sb_pwm_q    <= cfg_data_i[7:0];
        fhcc_pkg::REG_OFFPWM:   off_pwm_q   <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // captured item
  logic cmd_q, creq_q, allow_q;
  logic [TW-1:0] now_q;
  logic [1:0] sys_q, cm_q;
  logic signed [11:0] t_q, tt_q;
  logic [9:0] h_q, th_q;
  logic signed [15:0] pr_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q <= command_i;
      now_q <= TW'(now_ms_i);
      sys_q <= system_mode_i;
      cm_q <= control_mode_i;
      t_q <= temperature_i;
      h_q <= humidity_i;
      tt_q <= target_temp_i;
      th_q <= target_humidity_i;
      creq_q <= cooldown_required_i;
      allow_q <= heater_allowed_i;
      pr_q <= power_request_i;
    end
  end

  // control state
  fhcc_pkg::fan_mode_e mode_q, mode_d;
  logic [TW-1:0] entry_q, entry_d, cyc_start_q, cyc_start_d, ramp_start_q;
  logic was_on_q, was_on_d, phase_q, phase_d, ramp_act_q;
  logic [7:0] heat_q, heat_d, fan_now_q, fan_goal_q;
  logic [7:0] prop_q;

  // state update, combinational
  always_comb begin
    logic is_on, is_sb, is_off, tempm;
    logic [TW-1:0] dur, cdur;
    logic [7:0] pw;
    logic signed [12:0] t13, tt13;
    logic [10:0] h11, th11;
    is_on = sys_q == fhcc_pkg::SYS_ON;
    is_sb = sys_q == fhcc_pkg::SYS_SB;
    is_off = !is_on && !is_sb;
    tempm = cm_q <= 2'd1;
    t13 = 13'(t_q);
    tt13 = 13'(tt_q);
    h11 = 11'(h_q);
    th11 = 11'(th_q);
    pw = '0;
    mode_d = mode_q;
    entry_d = entry_q;
    was_on_d = was_on_q;
    heat_d = heat_q;
    phase_d = phase_q;
    cyc_start_d = cyc_start_q;
    dur = now_q - entry_q;
    cdur = now_q - cyc_start_q;
    if (cmd_q) begin
      if (pr_q < 0) pw = 8'd0;
      else if (pr_q > 16'sd255) pw = 8'd255;
      else pw = pr_q[7:0];
      heat_d = pw;
      if (heat_q != 0 && pw == 0) was_on_d = 1'b1;
    end else begin
      if (creq_q && mode_q != fhcc_pkg::M_COOL) begin
        mode_d = fhcc_pkg::M_COOL;
        entry_d = now_q;
      end
      case (mode_d)
        fhcc_pkg::M_OFF, fhcc_pkg::M_SB_OFF: begin
          mode_d = is_on ? fhcc_pkg::M_ON : (is_sb ? fhcc_pkg::M_CYC_ON : fhcc_pkg::M_SB_OFF);
        end
        fhcc_pkg::M_ON: begin
          if (!is_on) begin
            if (was_on_q) mode_d = fhcc_pkg::M_COOL;
            else if (is_sb) mode_d = fhcc_pkg::M_CYC_ON;
            else mode_d = fhcc_pkg::M_SB_OFF;
          end
        end
        fhcc_pkg::M_COOL: begin
          if (is_on) mode_d = fhcc_pkg::M_ON;
          else if ({32'd0, dur} >= {{TW{1'b0}}, cool_time_q} && !creq_q) begin
            was_on_d = 1'b0;
            mode_d = is_sb ? fhcc_pkg::M_CYC_ON : fhcc_pkg::M_SB_OFF;
          end
        end
        fhcc_pkg::M_CYC_ON: begin
          if (tempm) begin
            if (t_q < tlimit_q && t_q < tt_q && !phase_q) begin
              heat_d = 8'd255;
            end else if (t_q > tt_q && !phase_q) begin
              heat_d = 8'd0;
              phase_d = 1'b1;
            end else if (t_q < tt_q && phase_q) begin
              heat_d = 8'd0;
              phase_d = 1'b0;
              mode_d = fhcc_pkg::M_CYC_OFF;
            end
          end else begin
            if (t_q < tlimit_q && h_q > th_q && !phase_q) begin
              heat_d = 8'd255;
            end else if (h_q < th_q && !phase_q) begin
              heat_d = 8'd0;
              cyc_start_d = now_q;
              phase_d = 1'b1;
            end else if (phase_q && {32'd0, cdur} >= {{TW{1'b0}}, cool_time_q}) begin
              mode_d = fhcc_pkg::M_CYC_OFF;
              phase_d = 1'b0;
            end
          end
          if (heat_q != 0 && heat_d == 0) was_on_d = 1'b1;
          if (is_on) mode_d = fhcc_pkg::M_ON;
          else if (is_off) mode_d = fhcc_pkg::M_SB_OFF;
        end
        fhcc_pkg::M_CYC_OFF: begin
          if (is_on) mode_d = fhcc_pkg::M_ON;
          else if (is_off) mode_d = fhcc_pkg::M_SB_OFF;
          else if (tempm && t13 < tt13 - 13'(fhcc_pkg::TEMP_REARM)) mode_d = fhcc_pkg::M_CYC_ON;
          else if (!tempm && h11 > th11 + 11'(fhcc_pkg::HUM_REARM))
            mode_d = fhcc_pkg::M_CYC_ON;
        end
        default: mode_d = fhcc_pkg::M_SB_OFF;
      endcase
      // entry time moves on any change of mode since the start of this update
      if (mode_d != mode_q) entry_d = now_q;
    end
  end

  // ramp divider: restoring, quotient of (|diff|*el [+T-1]) / T
  logic [DB-1:0] num_q, quo_q;
  logic [16:0] rem_q;
  logic [CW-1:0] cnt_q;
  logic need_div_q, neg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= fhcc_pkg::M_OFF;
      entry_q <= '0;
      was_on_q <= 1'b0;
      heat_q <= '0;
      phase_q <= 1'b0;
      cyc_start_q <= '0;
      fan_now_q <= '0;
      fan_goal_q <= '0;
      ramp_start_q <= '0;
      ramp_act_q <= 1'b0;
    end else begin
      if (cmd_i.fsm) begin
        mode_q <= mode_d;
        entry_q <= entry_d;
        was_on_q <= was_on_d;
        heat_q <= heat_d;
        phase_q <= phase_d;
        cyc_start_q <= cyc_start_d;
      end
      if (cmd_i.goal) begin
        logic [7:0] g;
        case (mode_q)
          fhcc_pkg::M_ON:     g = prop_q;
          fhcc_pkg::M_COOL:   g = cool_pwm_q;
          fhcc_pkg::M_CYC_ON: g = sb_pwm_q;
          default:            g = off_pwm_q;
        endcase
        if (g != fan_goal_q) begin
          fan_goal_q <= g;
          ramp_start_q <= now_q;
          ramp_act_q <= 1'b1;
        end
      end
      if (cmd_i.finish && !cmd_q && need_div_q) begin
        fan_now_q <= neg_q ? fan_now_q - quo_q[7:0] : fan_now_q + quo_q[7:0];
      end else if (cmd_i.finish && !cmd_q && ramp_act_q) begin
        fan_now_q <= fan_goal_q;
        ramp_act_q <= 1'b0;
      end
    end
  end

  // proportional fan speed: heat*(255-min)/255 + min, division by constant
  logic [15:0] prod_q;
  logic prop_phase_q;
  always_ff @(posedge clk_i) begin
    logic [15:0] p;
    logic [8:0] q;
    logic [8:0] s;
    if (cmd_i.fsm) prod_q <= 16'(heat_d) * 16'(8'(fhcc_pkg::PWM_MAX) - min_pwm_q);
    if (cmd_i.prop) begin
      p = prod_q;
      // x/255 for x < 65535: (x + (x>>8) + 1) >> 8
      q = 9'((17'(p) + 17'(p[15:8]) + 17'd1) >> 8);
      s = q + 9'(min_pwm_q);
      prop_q <= (s > 9'(fhcc_pkg::PWM_MAX)) ? 8'(fhcc_pkg::PWM_MAX) : s[7:0];
    end
    prop_phase_q <= cmd_i.prop;
  end

  // set up division after goal chosen (uses updated goal/start via next-cycle regs)
  logic setup_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) setup_q <= 1'b0;
    else setup_q <= cmd_i.goal;
  end

  always_ff @(posedge clk_i) begin
    if (setup_q) begin
      logic [TW-1:0] el;
      logic [8:0] d;
      logic [7:0] ad;
      logic [DB-1:0] n;
      el = now_q - ramp_start_q;
      d = {1'b0, fan_goal_q} - {1'b0, fan_now_q};
      ad = d[8] ? 8'(-d) : d[7:0];
      need_div_q <= ramp_act_q && ({32'd0, el} < {{TW{1'b0}}, 16'd0, ramp_time_q});
      neg_q <= d[8];
      n = DB'(ad) * DB'(el[15:0]);
      if (d[8]) n = n + DB'(ramp_time_q) - DB'(1);
      num_q <= n;
      rem_q <= '0;
      quo_q <= '0;
      cnt_q <= CW'(DB);
    end else if (cmd_i.div_step) begin
      logic [16:0] r;
      r = {rem_q[15:0], num_q[DB-1]};
      num_q <= {num_q[DB-2:0], 1'b0};
      if (r >= {1'b0, ramp_time_q}) begin
        rem_q <= r - {1'b0, ramp_time_q};
        quo_q <= {quo_q[DB-2:0], 1'b1};
      end else begin
        rem_q <= r;
        quo_q <= {quo_q[DB-2:0], 1'b0};
      end
      cnt_q <= cnt_q - CW'(1);
    end
  end

  assign sts_o.is_power = cmd_q;
  assign sts_o.need_div = need_div_q && !setup_q && !prop_phase_q;
  assign sts_o.div_done = cnt_q == '0;

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      heater_pwm_o <= allow_q ? heat_q : 8'd0;
      fan_mode_o <= mode_q;
      fan_running_o <= mode_q != fhcc_pkg::M_OFF && mode_q != fhcc_pkg::M_CYC_OFF;
      heater_on_o <= heat_q != 0 && allow_q;
    end
  end
  assign fan_pwm_o = fan_now_q;

endmodule
`default_nettype wire

### sv/fan_heater_climate_controller.sv
// Fan and heater climate controller. Each item is either a control update (command 0) that
// steps the six-state fan machine and the fan ramp at timestamp now_ms_i, or a heater power
// set (command 1). Exactly one result item follows every input item. Both kinds pass the
// FSM and output states; a control update also passes the proportional, goal, setup and
// divide states, the bit-serial divider computing the ramp step while a fan ramp is in
// progress. Each item waits in its output state while the previous result is still held
// on the output. Configuration is written through cfg_we_i / cfg_index_i / cfg_data_i,
// by the user only while the block is idle; the block itself does not enforce this.
`default_nettype none
`include "assert_macros.svh"
module fan_heater_climate_controller #(
  parameter int TIME_WIDTH = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [2:0]         cfg_index_i,
  input  wire logic [31:0]        cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               command_i,
  input  wire logic [31:0]        now_ms_i,
  input  wire logic [1:0]         system_mode_i,
  input  wire logic [1:0]         control_mode_i,
  input  wire logic signed [11:0] temperature_i,
  input  wire logic [9:0]         humidity_i,
  input  wire logic signed [11:0] target_temp_i,
  input  wire logic [9:0]         target_humidity_i,
  input  wire logic               cooldown_required_i,
  input  wire logic               heater_allowed_i,
  input  wire logic signed [15:0] power_request_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [7:0]              fan_pwm_o,
  output logic [7:0]              heater_pwm_o,
  output logic [2:0]              fan_mode_o,
  output logic                    fan_running_o,
  output logic                    heater_on_o
);

  fhcc_pkg::cmd_t cmd;
  fhcc_pkg::sts_t sts;

  fhcc_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  fhcc_dp #(.TIME_WIDTH(TIME_WIDTH)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .command_i, .now_ms_i, .system_mode_i, .control_mode_i, .temperature_i,
    .humidity_i, .target_temp_i, .target_humidity_i, .cooldown_required_i,
    .heater_allowed_i, .power_request_i,
    .fan_pwm_o, .heater_pwm_o, .fan_mode_o, .fan_running_o, .heater_on_o
  );

  `ASSERT_IMPL(a_run_flag, clk_i, rst_ni, out_valid_o,
    fan_running_o == (fan_mode_o != fhcc_pkg::M_OFF && fan_mode_o != fhcc_pkg::M_CYC_OFF),
    "fan_running mismatch")
  `ASSERT_IMPL(a_heat_on, clk_i, rst_ni, out_valid_o,
    heater_on_o == (heater_pwm_o != 8'd0), "heater_on mismatch")
  `ASSERT_NEXT(a_load_busy, clk_i, rst_ni, in_valid_i && in_ready_o,
    !in_ready_o, "item accepted while busy")

endmodule
`default_nettype wire

### verif/fan_heater_climate_controller_test.sv
`default_nettype none
module fan_heater_climate_controller_test;

  localparam int STALL_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 80;

  typedef struct {
    logic               command;
    logic [31:0]        now_ms;
    logic [1:0]         system_mode;
    logic [1:0]         control_mode;
    logic signed [11:0] temperature;
    logic [9:0]         humidity;
    logic signed [11:0] target_temp;
    logic [9:0]         target_humidity;
    logic               cooldown_required;
    logic               heater_allowed;
    logic signed [15:0] power_request;
  } ctl_item_t;

  typedef struct {
    logic [7:0] fan_pwm;
    logic [7:0] heater_pwm;
    logic [2:0] fan_mode;
    logic       fan_running;
    logic       heater_on;
  } fan_status_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic command_i = 1'b0;
  logic [31:0] now_ms_i = '0;
  logic [1:0] system_mode_i = '0;
  logic [1:0] control_mode_i = '0;
  logic signed [11:0] temperature_i = '0;
  logic [9:0] humidity_i = '0;
  logic signed [11:0] target_temp_i = '0;
  logic [9:0] target_humidity_i = '0;
  logic cooldown_required_i = 1'b0;
  logic heater_allowed_i = 1'b0;
  logic signed [15:0] power_request_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [7:0] fan_pwm_o;
  logic [7:0] heater_pwm_o;
  logic [2:0] fan_mode_o;
  logic fan_running_o;
  logic heater_on_o;

  fan_heater_climate_controller dut (.*);

  always #5 clk_i = ~clk_i;

  // model of the controller: configuration
  logic [31:0] m_cooldown_ms;
  logic [15:0] m_ramp_ms;
  logic signed [11:0] m_temp_limit;
  logic [7:0] m_min_pwm, m_cool_pwm, m_sb_pwm, m_off_pwm;
  // model of the controller: state
  fhcc_pkg::fan_mode_e m_mode;
  logic [31:0] m_mode_entry;
  logic m_heater_was_on;
  logic [7:0] m_heater_level;
  logic m_cycle_phase;
  logic [31:0] m_cycle_start;
  logic [7:0] m_fan_now, m_fan_goal;
  logic [31:0] m_ramp_start;
  logic m_ramp_active;

  fan_status_t expected_status[$];
  int fails = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;
  logic [31:0] clock_ms = 32'd0;

  task automatic enter_mode(fhcc_pkg::fan_mode_e m, logic [31:0] now);
    if (m_mode != m) begin
      m_mode = m;
      m_mode_entry = now;
    end
  endtask

  task automatic load_heater(logic [7:0] p);
    logic was;
    was = m_heater_level != 0;
    m_heater_level = p;
    if (was && p == 0) m_heater_was_on = 1'b1;
  endtask

  task automatic step_fan_machine(input ctl_item_t it);
    logic [31:0] now, dur, el;
    logic is_on, is_sb, is_off, creq;
    int t, h, tt, th, prop;
    logic [7:0] goal;
    longint diff, span, delta, n;
    now = it.now_ms;
    is_on = it.system_mode == fhcc_pkg::SYS_ON;
    is_sb = it.system_mode == fhcc_pkg::SYS_SB;
    is_off = !is_on && !is_sb;
    creq = it.cooldown_required;
    t = it.temperature;
    h = it.humidity;
    tt = it.target_temp;
    th = it.target_humidity;
    dur = now - m_mode_entry;
    if (creq && m_mode != fhcc_pkg::M_COOL) enter_mode(fhcc_pkg::M_COOL, now);
    case (m_mode)
      fhcc_pkg::M_OFF, fhcc_pkg::M_SB_OFF: begin
        if (is_on) enter_mode(fhcc_pkg::M_ON, now);
        else if (is_sb) enter_mode(fhcc_pkg::M_CYC_ON, now);
        else enter_mode(fhcc_pkg::M_SB_OFF, now);
      end
      fhcc_pkg::M_ON: begin
        if (!is_on) begin
          if (m_heater_was_on) enter_mode(fhcc_pkg::M_COOL, now);
          else if (is_sb) enter_mode(fhcc_pkg::M_CYC_ON, now);
          else enter_mode(fhcc_pkg::M_SB_OFF, now);
        end
      end
      fhcc_pkg::M_COOL: begin
        if (is_on) enter_mode(fhcc_pkg::M_ON, now);
        else if (dur >= m_cooldown_ms && !creq) begin
          m_heater_was_on = 1'b0;
          enter_mode(is_sb ? fhcc_pkg::M_CYC_ON : fhcc_pkg::M_SB_OFF, now);
        end
      end
      fhcc_pkg::M_CYC_ON: begin
        if (it.control_mode <= 2'd1) begin
          if (t < m_temp_limit && t < tt && !m_cycle_phase) load_heater(8'd255);
          else if (t > tt && !m_cycle_phase) begin
            load_heater(8'd0);
            m_cycle_phase = 1'b1;
          end else if (t < tt && m_cycle_phase) begin
            load_heater(8'd0);
            m_cycle_phase = 1'b0;
            enter_mode(fhcc_pkg::M_CYC_OFF, now);
          end
        end else begin
          if (t < m_temp_limit && h > th && !m_cycle_phase) load_heater(8'd255);
          else if (h < th && !m_cycle_phase) begin
            load_heater(8'd0);
            m_cycle_start = now;
            m_cycle_phase = 1'b1;
          end else if (m_cycle_phase && (now - m_cycle_start) >= m_cooldown_ms) begin
            enter_mode(fhcc_pkg::M_CYC_OFF, now);
            m_cycle_phase = 1'b0;
          end
        end
        if (is_on) enter_mode(fhcc_pkg::M_ON, now);
        else if (is_off) enter_mode(fhcc_pkg::M_SB_OFF, now);
      end
      fhcc_pkg::M_CYC_OFF: begin
        if (is_on) enter_mode(fhcc_pkg::M_ON, now);
        else if (is_off) enter_mode(fhcc_pkg::M_SB_OFF, now);
        else if (it.control_mode <= 2'd1 && t < tt - fhcc_pkg::TEMP_REARM)
          enter_mode(fhcc_pkg::M_CYC_ON, now);
        else if (it.control_mode >= 2'd2 && h > th + fhcc_pkg::HUM_REARM)
          enter_mode(fhcc_pkg::M_CYC_ON, now);
      end
      default: enter_mode(fhcc_pkg::M_SB_OFF, now);
    endcase

    case (m_mode)
      fhcc_pkg::M_ON: begin
        prop = int'(m_heater_level) * (fhcc_pkg::PWM_MAX - int'(m_min_pwm)) / fhcc_pkg::PWM_MAX
               + int'(m_min_pwm);
        goal = (prop > fhcc_pkg::PWM_MAX) ? 8'd255 : prop[7:0];
      end
      fhcc_pkg::M_COOL: goal = m_cool_pwm;
      fhcc_pkg::M_CYC_ON: goal = m_sb_pwm;
      default: goal = m_off_pwm;
    endcase
    if (goal != m_fan_goal) begin
      m_fan_goal = goal;
      m_ramp_start = now;
      m_ramp_active = 1'b1;
    end

    if (m_ramp_active) begin
      el = now - m_ramp_start;
      if (el >= {16'd0, m_ramp_ms}) begin
        m_fan_now = m_fan_goal;
        m_ramp_active = 1'b0;
      end else begin
        diff = longint'(m_fan_goal) - longint'(m_fan_now);
        span = longint'(m_ramp_ms);
        if (diff >= 0) delta = diff * longint'(el) / span;
        else begin
          // round toward the goal on the way down
          n = -diff * longint'(el);
          delta = -((n + span - 1) / span);
        end
        m_fan_now = 8'(longint'(m_fan_now) + delta);
      end
    end
  endtask

  function automatic logic [7:0] clamp_power(logic signed [15:0] p);
    if (p < 0) return 8'd0;
    if (p > 255) return 8'd255;
    return p[7:0];
  endfunction

  task automatic predict_status(input ctl_item_t it);
    fan_status_t s;
    if (it.command) load_heater(clamp_power(it.power_request));
    else step_fan_machine(it);
    s.fan_pwm = m_fan_now;
    s.heater_pwm = it.heater_allowed ? m_heater_level : 8'd0;
    s.fan_mode = m_mode;
    s.fan_running = m_mode != fhcc_pkg::M_OFF && m_mode != fhcc_pkg::M_CYC_OFF;
    s.heater_on = m_heater_level != 0 && it.heater_allowed;
    expected_status.push_back(s);
  endtask

  task automatic send_item(input ctl_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i <= it.command;
    now_ms_i <= it.now_ms;
    system_mode_i <= it.system_mode;
    control_mode_i <= it.control_mode;
    temperature_i <= it.temperature;
    humidity_i <= it.humidity;
    target_temp_i <= it.target_temp;
    target_humidity_i <= it.target_humidity;
    cooldown_required_i <= it.cooldown_required;
    heater_allowed_i <= it.heater_allowed;
    power_request_i <= it.power_request;
    do @(posedge clk_i); while (!in_ready_o);
    predict_status(it);
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    while (expected_status.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(fhcc_pkg::reg_idx_e idx, logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      fhcc_pkg::REG_COOLDOWN: m_cooldown_ms = val;
      fhcc_pkg::REG_RAMP: m_ramp_ms = val[15:0];
      fhcc_pkg::REG_TLIMIT: m_temp_limit = val[11:0];
      fhcc_pkg::REG_MINPWM: m_min_pwm = val[7:0];
      fhcc_pkg::REG_COOLPWM: m_cool_pwm = val[7:0];
      fhcc_pkg::REG_SBPWM: m_sb_pwm = val[7:0];
      default: m_off_pwm = val[7:0];
    endcase
  endtask

  task automatic apply_settings(logic [31:0] cool_ms, logic [15:0] ramp_ms,
                                int tlimit, logic [7:0] min_p, logic [7:0] cool_p,
                                logic [7:0] sb_p, logic [7:0] off_p);
    drain();
    write_reg(fhcc_pkg::REG_COOLDOWN, cool_ms);
    write_reg(fhcc_pkg::REG_RAMP, {16'd0, ramp_ms});
    write_reg(fhcc_pkg::REG_TLIMIT, 32'(tlimit));
    write_reg(fhcc_pkg::REG_MINPWM, {24'd0, min_p});
    write_reg(fhcc_pkg::REG_COOLPWM, {24'd0, cool_p});
    write_reg(fhcc_pkg::REG_SBPWM, {24'd0, sb_p});
    write_reg(fhcc_pkg::REG_OFFPWM, {24'd0, off_p});
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic ctl_item_t update_item(logic [31:0] now, logic [1:0] sys,
                                            logic [1:0] cm, int t, int h, int tt, int th,
                                            logic creq, logic allow);
    ctl_item_t it;
    it.command = 1'b0;
    it.now_ms = now;
    it.system_mode = sys;
    it.control_mode = cm;
    it.temperature = 12'(t);
    it.humidity = 10'(h);
    it.target_temp = 12'(tt);
    it.target_humidity = 10'(th);
    it.cooldown_required = creq;
    it.heater_allowed = allow;
    it.power_request = 16'($urandom);
    return it;
  endfunction

  function automatic ctl_item_t power_item(int p, logic allow);
    ctl_item_t it;
    it = update_item($urandom, 2'($urandom), 2'($urandom), 0, 0, 0, 0, 1'b0, allow);
    it.command = 1'b1;
    it.power_request = 16'(p);
    return it;
  endfunction

  // corners: power clamps, every system mode, field extremes, wrapping timestamps
  task automatic test_directed;
    send_item(power_item(-32768, 1'b1));
    send_item(power_item(32767, 1'b1));
    send_item(power_item(255, 1'b0));
    send_item(update_item(32'd0, fhcc_pkg::SYS_ON, 2'd0, -400, 0, 1250, 1000, 1'b0, 1'b1));
    send_item(update_item(32'd500, fhcc_pkg::SYS_ON, 2'd1, 1250, 1000, -400, 0, 1'b0, 1'b1));
    send_item(power_item(0, 1'b1));
    send_item(update_item(32'd3000, fhcc_pkg::SYS_SB, 2'd0, -400, 0, 1250, 0, 1'b0, 1'b1));
    send_item(update_item(32'd3500, fhcc_pkg::SYS_SB, 2'd0, 1250, 0, 0, 0, 1'b0, 1'b1));
    send_item(update_item(32'd4000, fhcc_pkg::SYS_SB, 2'd1, -400, 0, 0, 0, 1'b0, 1'b1));
    send_item(update_item(32'd4500, fhcc_pkg::SYS_SB, 2'd1, -400, 0, 1250, 0, 1'b0, 1'b1));
    send_item(update_item(32'd5000, fhcc_pkg::SYS_SB, 2'd2, 0, 1000, 0, 0, 1'b0, 1'b1));
    send_item(update_item(32'd5500, fhcc_pkg::SYS_SB, 2'd3, 0, 0, 0, 1000, 1'b0, 1'b0));
    send_item(update_item(32'hFFFF_FF00, fhcc_pkg::SYS_SB, 2'd3, 0, 0, 0, 1000, 1'b0, 1'b1));
    send_item(update_item(32'd200, fhcc_pkg::SYS_BAD, 2'd2, 0, 0, 0, 0, 1'b0, 1'b1));
    send_item(update_item(32'd300, fhcc_pkg::SYS_ON, 2'd0, 0, 0, 0, 0, 1'b1, 1'b1));
    send_item(update_item(32'd400, fhcc_pkg::SYS_ON, 2'd0, 0, 0, 0, 0, 1'b1, 1'b0));
    send_item(update_item(32'd700, fhcc_pkg::SYS_OFF, 2'd0, 0, 0, 0, 0, 1'b1, 1'b1));
    send_item(update_item(32'hFFFF_FFFF, fhcc_pkg::SYS_OFF, 2'd0, 0, 0, 0, 0, 1'b0, 1'b1));
    send_item(update_item(32'd90000, fhcc_pkg::SYS_OFF, 2'd0, 0, 0, 0, 0, 1'b0, 1'b1));
    send_item(update_item(32'd91000, fhcc_pkg::SYS_BAD, 2'd0, 0, 0, 0, 0, 1'b0, 1'b1));
    clock_ms = 32'd91000;
  endtask

  // realistic sessions: slowly moving time, sticky modes, readings near target
  task automatic test_sessions(int count);
    ctl_item_t it;
    logic [1:0] sys, cm;
    int tt, th, t, h;
    sys = 2'($urandom_range(2));
    cm = 2'($urandom);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(9) == 0) sys = 2'($urandom);
      if ($urandom_range(19) == 0) cm = 2'($urandom);
      if ($urandom_range(5) == 0)
        send_item(power_item($urandom_range(7) == 0 ? int'($signed(16'($urandom)))
                                                    : int'($urandom_range(255)),
                             $urandom_range(4) != 0));
      else begin
        if ($urandom_range(39) == 0) clock_ms = $urandom;
        else clock_ms = clock_ms + $urandom_range(($urandom_range(3) == 0) ? 70000 : 2500);
        tt = $urandom_range(1650) - 400;
        th = $urandom_range(1000);
        if ($urandom_range(9) == 0) begin
          t = $urandom_range(1650) - 400;
          h = $urandom_range(1000);
        end else begin
          t = tt + $urandom_range(80) - 40;
          h = th + $urandom_range(60) - 30;
          if (t < -400) t = -400;
          if (t > 1250) t = 1250;
          if (h < 0) h = 0;
          if (h > 1000) h = 1000;
        end
        it = update_item(clock_ms, sys, cm, t, h, tt, th, $urandom_range(19) == 0,
                         $urandom_range(4) != 0);
        send_item(it);
      end
    end
  endtask

  task automatic run_phase(int idle, int stall, int count);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    test_sessions(count);
  endtask

  always @(posedge clk_i) begin
    out_ready_i <= $urandom_range(99) >= recv_stall_pct;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_status.size() == 0) begin
        $display("%0t: unexpected item fan_pwm=%0d heater_pwm=%0d mode=%0d", $time,
                 fan_pwm_o, heater_pwm_o, fan_mode_o);
        fails++;
      end else begin
        fan_status_t e;
        e = expected_status.pop_front();
        if (fan_pwm_o !== e.fan_pwm) begin
          $display("%0t: fan_pwm expected %0d actual %0d", $time, e.fan_pwm, fan_pwm_o);
          fails++;
        end
        if (heater_pwm_o !== e.heater_pwm) begin
          $display("%0t: heater_pwm expected %0d actual %0d", $time, e.heater_pwm,
                   heater_pwm_o);
          fails++;
        end
        if (fan_mode_o !== e.fan_mode) begin
          $display("%0t: fan_mode expected %0d actual %0d", $time, e.fan_mode, fan_mode_o);
          fails++;
        end
        if (fan_running_o !== e.fan_running) begin
          $display("%0t: fan_running expected %0b actual %0b", $time, e.fan_running,
                   fan_running_o);
          fails++;
        end
        if (heater_on_o !== e.heater_on) begin
          $display("%0t: heater_on expected %0b actual %0b", $time, e.heater_on,
                   heater_on_o);
          fails++;
        end
      end
    end
  end

  // watchdog on handshake progress
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || !rst_ni)
      quiet_cycles <= 0;
    else if (quiet_cycles >= STALL_LIMIT) begin
      $display("fan_heater_climate_controller test failed");
      $finish;
    end else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    m_cooldown_ms = 32'd60000;
    m_ramp_ms = 16'd2000;
    m_temp_limit = 12'sd600;
    m_min_pwm = 8'd100;
    m_cool_pwm = 8'd255;
    m_sb_pwm = 8'd128;
    m_off_pwm = 8'd0;
    m_mode = fhcc_pkg::M_OFF;
    m_mode_entry = '0;
    m_heater_was_on = 1'b0;
    m_heater_level = '0;
    m_cycle_phase = 1'b0;
    m_cycle_start = '0;
    m_fan_now = '0;
    m_fan_goal = '0;
    m_ramp_start = '0;
    m_ramp_active = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    run_phase(0, 0, 120);
    apply_settings(32'd1500, 16'd300, 600, 8'd100, 8'd200, 8'd128, 8'd10);
    run_phase(72, 0, 130);
    apply_settings(32'd0, 16'd1, -400, 8'd0, 8'd0, 8'd255, 8'd255);
    run_phase(0, 72, 110);
    apply_settings(32'hFFFF_FFFF, 16'd65535, 1250, 8'd255, 8'd255, 8'd0, 8'd0);
    run_phase(11, 11, 110);
    // zero ramp length finishes the ramp at once
    apply_settings(32'd800, 16'd0, 300, 8'd37, 8'd170, 8'd90, 8'd3);
    run_phase(0, 0, 80);
    apply_settings(32'd5000, 16'd4000, 900, 8'd60, 8'd230, 8'd140, 8'd20);
    run_phase(72, 72, 60);
    run_phase(0, 0, 60);
    run_phase(11, 11, 60);

    drain();
    if (fails == 0) $display("fan_heater_climate_controller test passed");
    else $display("fan_heater_climate_controller test failed");
    $finish;
  end
endmodule
`default_nettype wire
